### rtl/core/tbg_pkg.sv
// ============================================================================
// tbg_pkg: shared types and constants of the touch backlight gesture block
// Holds the register map, the reset values and the item and state structs.
// ============================================================================
`default_nettype none

package tbg_pkg;

  // Timestamps are kept and compared modulo 2^TIME_BITS.
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned NOW_W     = 32;
  localparam int unsigned Y_W       = 9;
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned GAIN_W    = 10;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 16;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [LEVEL_W-1:0]   level_t;

  localparam level_t LEVEL_FULL  = 8'd255;
  localparam level_t LEVEL_RESET = 8'd200;
  localparam level_t LEVEL_ZERO  = 8'd0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_TAP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWIPE_GAIN = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_STEP  = 8'd3;

  localparam logic [15:0]       RST_DOUBLE_TAP = 16'd300;
  localparam logic [15:0]       RST_LONG_PRESS = 16'd600;
  localparam logic [GAIN_W-1:0] RST_SWIPE_GAIN = 10'd123;
  localparam level_t            RST_HOLD_STEP  = 8'd2;

  typedef struct packed {
    logic [15:0]       double_tap_window_ms;
    logic [15:0]       long_press_ms;
    logic [GAIN_W-1:0] swipe_gain_q10;
    level_t            hold_dim_step;
  } tbg_cfg_t;

  typedef struct packed {
    logic           touch_present;
    logic [Y_W-1:0] touch_y;
    logic [NOW_W-1:0] now_ms;
  } tbg_in_t;

  typedef struct packed {
    level_t level;
    logic   level_written;
    logic   long_press_active;
    logic   hold_step_taken;
  } tbg_out_t;

  typedef struct packed {
    level_t         level;
    logic           touch_active;
    logic           long_press;
    logic [Y_W-1:0] prev_y;
    time_t          last_start;
    time_t          press_start;
  } tbg_state_t;

endpackage

`default_nettype wire

### rtl/core/tbg_ifs.sv
// ============================================================================
// tbg_ifs: handshake channels of the touch backlight gesture block
// Poll input channel, result channel and register write channel.
// ============================================================================
`default_nettype none

interface tbg_in_if import tbg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             touch_present;
  logic [Y_W-1:0]   touch_y;
  logic [NOW_W-1:0] now_ms;

  modport source (output valid, touch_present, touch_y, now_ms, input ready);
  modport sink   (input valid, touch_present, touch_y, now_ms, output ready);
endinterface

interface tbg_out_if import tbg_pkg::*; ();
  logic   valid;
  logic   ready;
  level_t level;
  logic   level_written;
  logic   long_press_active;
  logic   hold_step_taken;

  modport source (output valid, level, level_written, long_press_active,
                  hold_step_taken, input ready);
  modport sink   (input valid, level, level_written, long_press_active,
                  hold_step_taken, output ready);
endinterface

interface tbg_cfg_if import tbg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/tbg_step.sv
// ============================================================================
// tbg_step: one poll of the gesture state machine
// Computes the next state and the result item from the current state.
// ============================================================================
`default_nettype none

module tbg_step import tbg_pkg::*; (
  input  wire tbg_cfg_t   cfg,
  input  wire tbg_state_t cur,
  input  wire tbg_in_t    item,
  output tbg_state_t      nxt,
  output tbg_out_t        res
);

  logic               start;
  time_t              now_t;
  logic               dtap;
  level_t             lvl_a;
  logic               flag_a;
  logic [Y_W-1:0]     prev_a;
  time_t              press_a;
  logic signed [10:0] dy;
  logic signed [21:0] prod;
  logic signed [21:0] sum;
  logic [10:0]        quo;
  level_t             lvl_b;
  logic               flag_b;
  logic               hold;
  level_t             lvl_c;

  assign now_t   = TIME_BITS'(item.now_ms);
  assign start   = !cur.touch_active;
  assign dtap    = (time_t'(now_t - cur.last_start) < TIME_BITS'(cfg.double_tap_window_ms));
  assign lvl_a   = (start && dtap) ? LEVEL_FULL : cur.level;
  assign flag_a  = start ? 1'b0 : cur.long_press;
  assign prev_a  = start ? item.touch_y : cur.prev_y;
  assign press_a = start ? now_t : cur.press_start;

  // Swipe: level*1024 + dy*gain, floored by the shift and clamped to 0..255.
  assign dy   = $signed({2'b00, prev_a}) - $signed({2'b00, item.touch_y});
  assign prod = $signed({{11{dy[10]}}, dy}) * $signed({12'b0, cfg.swipe_gain_q10});
  assign sum  = $signed({4'b0000, lvl_a, 10'b0}) + prod;
  assign quo  = sum[20:10];

  always_comb begin
    if (flag_a) begin
      lvl_b = lvl_a;
    end else if (sum[21]) begin
      lvl_b = LEVEL_ZERO;
    end else if (quo > 11'(LEVEL_FULL)) begin
      lvl_b = LEVEL_FULL;
    end else begin
      lvl_b = quo[LEVEL_W-1:0];
    end
  end

  assign flag_b = flag_a ||
                  (time_t'(now_t - press_a) > TIME_BITS'(cfg.long_press_ms));
  assign hold   = flag_b && (lvl_b != LEVEL_ZERO);
  assign lvl_c  = !hold ? lvl_b :
                  (lvl_b > cfg.hold_dim_step) ? lvl_b - cfg.hold_dim_step : LEVEL_ZERO;

  always_comb begin
    nxt = cur;
    res = '0;
    if (item.touch_present) begin
      nxt.level        = lvl_c;
      nxt.touch_active = 1'b1;
      nxt.long_press   = flag_b;
      nxt.prev_y       = flag_a ? prev_a : item.touch_y;
      nxt.press_start  = press_a;
      nxt.last_start   = start ? now_t : cur.last_start;
      res.level             = lvl_c;
      res.level_written     = (start && dtap) || !flag_a || hold;
      res.long_press_active = flag_b;
      res.hold_step_taken   = hold;
    end else begin
      nxt.touch_active = 1'b0;
      nxt.prev_y       = '0;
      res.level        = cur.level;
    end
  end

endmodule

`default_nettype wire

### rtl/core/touch_backlight_gesture.sv
// ============================================================================
// touch_backlight_gesture: backlight level control from touch panel polls
// Double tap, swipe and long-press dimming on a stream of poll items.
// ============================================================================
//
// Usage. Each item on in_chan is one poll of the touch panel: a touch flag,
// the vertical coordinate and a free-running millisecond time. For every
// accepted item exactly one result item leaves on out_chan with the new
// backlight level and three flags: level written, long press active and
// hold step taken. Registers are written on cfg_chan, which is always ready;
// writes to indexes above the four defined registers are dropped. Write the
// registers only while no poll is in flight.
//
// Flow. An accepted item sits in the input register while the gesture logic
// (one small multiplier, compares and a clamp) computes the next state, and
// moves to the result register at the next edge when that register is free;
// out_chan.valid is driven by the result register. One item is taken every
// cycle while the receiver keeps taking results.
//
// Stalls and reset. A result held by a stalled receiver does not block the
// input: one more item is still taken into the input register, after which
// in_chan.ready drops until the result is taken. Synchronous reset empties
// both registers, loads the register reset values and sets the level to 200.
// ============================================================================
`default_nettype none

module touch_backlight_gesture import tbg_pkg::*; (
  input wire         clk,
  input wire         rst_n,
  tbg_in_if.sink     in_chan,
  tbg_out_if.source  out_chan,
  tbg_cfg_if.sink    cfg_chan
);

  tbg_cfg_t   cfg_r;
  tbg_state_t state_r;
  tbg_state_t state_nxt;
  tbg_in_t    in_item_r;
  logic       in_vld_r;
  tbg_out_t   out_r;
  tbg_out_t   out_nxt;
  logic       out_vld_r;
  logic       adv;
  logic       in_take;

  // The input register advances when the result register is empty or drains.
  assign adv     = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || adv;
  assign in_take = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.double_tap_window_ms <= RST_DOUBLE_TAP;
      cfg_r.long_press_ms        <= RST_LONG_PRESS;
      cfg_r.swipe_gain_q10       <= RST_SWIPE_GAIN;
      cfg_r.hold_dim_step        <= RST_HOLD_STEP;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_DOUBLE_TAP: cfg_r.double_tap_window_ms <= cfg_chan.data;
        REG_LONG_PRESS: cfg_r.long_press_ms        <= cfg_chan.data;
        REG_SWIPE_GAIN: cfg_r.swipe_gain_q10       <= cfg_chan.data[GAIN_W-1:0];
        REG_HOLD_STEP:  cfg_r.hold_dim_step        <= cfg_chan.data[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.touch_present <= in_chan.touch_present;
      in_item_r.touch_y       <= in_chan.touch_y;
      in_item_r.now_ms        <= in_chan.now_ms;
    end
  end

  tbg_step u_step (
    .cfg  (cfg_r),
    .cur  (state_r),
    .item (in_item_r),
    .nxt  (state_nxt),
    .res  (out_nxt)
  );

  // Gesture state only moves when an item passes to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.level        <= LEVEL_RESET;
      state_r.touch_active <= 1'b0;
      state_r.long_press   <= 1'b0;
      state_r.prev_y       <= '0;
      state_r.last_start   <= '0;
      state_r.press_start  <= '0;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_chan.valid             = out_vld_r;
  assign out_chan.level             = out_r.level;
  assign out_chan.level_written     = out_r.level_written;
  assign out_chan.long_press_active = out_r.long_press_active;
  assign out_chan.hold_step_taken   = out_r.hold_step_taken;

  // A hold step always pushes the level and only happens in long press.
  a_step_written: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.hold_step_taken |-> out_r.level_written && out_r.long_press_active)
    else $error("hold step without level write or long press");

  // An item leaving the input register shows up as a result next cycle.
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("advanced item did not reach result register");

  // Gesture state holds while no item advances.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(state_r))
    else $error("gesture state changed without an item");

  // Both registers full and the receiver stalled: no further item is taken.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && out_vld_r && !out_chan.ready |-> !in_chan.ready)
    else $error("item accepted while both registers full and stalled");

endmodule

`default_nettype wire
